// File: hdl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the stride prefetch table
// Item structs, entry mode codes, state machine encodings and the write
// bundle that the back end hands to the entry table.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned DefEntries = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned AddrW      = 64;

  typedef enum logic [1:0] {
    MODE_INVALID  = 2'd0,
    MODE_TRAINING = 2'd1,
    MODE_ACTIVE   = 2'd2
  } spt_mode_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WAIT,
    F_SCAN
  } spt_fstate_e;

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } spt_bstate_e;

  typedef struct packed {
    logic [AddrW-1:0] instr_addr;
    logic [AddrW-1:0] data_addr;
    logic [AddrW-1:0] timestamp;
  } spt_req_t;

  typedef struct packed {
    logic             prefetch_valid;
    logic [AddrW-1:0] prefetch_addr;
    logic             stride_hit;
    logic             entry_dropped;
  } spt_res_t;

  // Tag and last-use time share one memory word.
  typedef struct packed {
    logic [AddrW-1:0] tag;
    logic [AddrW-1:0] last_use;
  } spt_tag_use_t;

  // Last address and stride share another.
  typedef struct packed {
    logic [AddrW-1:0] last_addr;
    logic [AddrW-1:0] stride;
  } spt_addr_stride_t;

  typedef struct packed {
    logic             tu_we;
    logic             ls_we;
    logic             mode_we;
    spt_mode_e        mode;
    spt_tag_use_t     tag_use;
    spt_addr_stride_t addr_stride;
  } spt_wr_t;

endpackage

// File: hdl/spt_fifo.sv
// ----------------------------------------------------------------------------
// spt_fifo: job queue between front end and back end
// Small register queue; holds classified items until the back end takes them.
// ----------------------------------------------------------------------------
module spt_fifo #(
  parameter int unsigned DataW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);
  import spt_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [DataW-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CntW'(QueueDepth) || pop_i))
    else $error("job queue overflow");
`endif

endmodule

// File: hdl/spt_table.sv
// ----------------------------------------------------------------------------
// spt_table: entry storage
// Tag/last-use memory read by the front-end sweep, last-address/stride
// memory read by the back end, and the per-entry mode flops.
// ----------------------------------------------------------------------------
module spt_table #(
  parameter int unsigned ENTRIES = spt_pkg::DefEntries,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      f_rd_en_i,
  input  logic [IW-1:0]             f_rd_idx_i,
  output spt_pkg::spt_tag_use_t     f_tag_use_o,
  input  logic                      b_rd_en_i,
  input  logic [IW-1:0]             b_rd_idx_i,
  output spt_pkg::spt_addr_stride_t b_addr_stride_o,
  input  logic [IW-1:0]             wr_idx_i,
  input  spt_pkg::spt_wr_t          wr_i,
  output spt_pkg::spt_mode_e        mode_o [ENTRIES]
);
  import spt_pkg::*;

  spt_tag_use_t     tu_mem     [ENTRIES];
  spt_addr_stride_t ls_mem     [ENTRIES];
  spt_tag_use_t     tu_rd_q;
  spt_addr_stride_t ls_rd_q;
  spt_mode_e        mode_q     [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.tu_we) begin
      tu_mem[wr_idx_i] <= wr_i.tag_use;
    end
    if (f_rd_en_i) begin
      tu_rd_q <= tu_mem[f_rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.ls_we) begin
      ls_mem[wr_idx_i] <= wr_i.addr_stride;
    end
    if (b_rd_en_i) begin
      ls_rd_q <= ls_mem[b_rd_idx_i];
    end
  end

  // Mode flops reset to invalid, so the data memories need no clearing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        mode_q[i] <= MODE_INVALID;
      end
    end else if (wr_i.mode_we) begin
      mode_q[wr_idx_i] <= wr_i.mode;
    end
  end

  assign f_tag_use_o     = tu_rd_q;
  assign b_addr_stride_o = ls_rd_q;
  assign mode_o          = mode_q;

endmodule

// File: hdl/spt_front.sv
// ----------------------------------------------------------------------------
// spt_front: item intake and entry selection
// Holds one item, sweeps the table one entry per cycle once the back end is
// quiet, and queues the item with its chosen entry and match flag.
// ----------------------------------------------------------------------------
module spt_front #(
  parameter int unsigned ENTRIES = spt_pkg::DefEntries,
  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned JobW = 1 + IW + $bits(spt_pkg::spt_req_t)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  spt_pkg::spt_req_t     req_i,
  input  logic                  quiet_i,
  input  spt_pkg::spt_mode_e    mode_i [ENTRIES],
  output logic                  rd_en_o,
  output logic [IW-1:0]         rd_idx_o,
  input  spt_pkg::spt_tag_use_t tag_use_i,
  output logic                  push_o,
  output logic [JobW-1:0]       job_o
);
  import spt_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  spt_fstate_e      state_q, state_d;
  spt_req_t         req_q, req_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cnt_m1;
  logic [IW-1:0]    eval_idx;
  logic             eval_valid;
  logic             match_q, match_d;
  logic [IW-1:0]    match_idx_q, match_idx_d;
  logic             free_q, free_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic [IW-1:0]    old_idx_q, old_idx_d;
  logic [AddrW-1:0] old_use_q, old_use_d;
  logic [IW-1:0]    pick_idx;

  assign cnt_m1     = cnt_q - 1'b1;
  assign eval_idx   = cnt_m1[IW-1:0];
  assign eval_valid = (mode_i[eval_idx] != MODE_INVALID);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    old_use_d   = old_use_q;
    rd_en_o     = 1'b0;
    push_o      = 1'b0;
    busy_o      = (state_q != F_IDLE);

    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = F_WAIT;
        end
      end
      F_WAIT: begin
        // Hold until every earlier item has written the table.
        if (quiet_i) begin
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          state_d = F_SCAN;
        end
      end
      F_SCAN: begin
        rd_en_o = (cnt_q != CW'(ENTRIES));
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          if (cnt_q == CW'(1)) begin
            old_idx_d = '0;
            old_use_d = tag_use_i.last_use;
          end else if (!match_q && eval_valid && tag_use_i.last_use < old_use_q) begin
            old_idx_d = eval_idx;
            old_use_d = tag_use_i.last_use;
          end
          if (!match_q && eval_valid && tag_use_i.tag == req_q.instr_addr) begin
            match_d     = 1'b1;
            match_idx_d = eval_idx;
          end
          if (!eval_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = eval_idx;
          end
        end
        if (cnt_q == CW'(ENTRIES)) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // Matching entry wins, then the first free one, then the oldest.
  assign pick_idx = match_d ? match_idx_d : (free_d ? free_idx_d : old_idx_d);
  assign rd_idx_o = cnt_q[IW-1:0];
  assign job_o    = {match_d, pick_idx, req_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_use_q   <= old_use_d;
  end

endmodule

// File: hdl/spt_back.sv
// ----------------------------------------------------------------------------
// spt_back: entry update and result
// Takes one queued job, reads the entry's last address and stride, checks the
// stride, writes the entry back and registers the result with a one-cycle strobe.
// ----------------------------------------------------------------------------
module spt_back #(
  parameter int unsigned ENTRIES = spt_pkg::DefEntries,
  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned JobW = 1 + IW + $bits(spt_pkg::spt_req_t)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  logic [JobW-1:0]           job_i,
  output logic                      pop_o,
  output logic                      rd_en_o,
  output logic [IW-1:0]             rd_idx_o,
  input  spt_pkg::spt_addr_stride_t addr_stride_i,
  input  spt_pkg::spt_mode_e        mode_i [ENTRIES],
  output logic [IW-1:0]             wr_idx_o,
  output spt_pkg::spt_wr_t          wr_o,
  output logic                      idle_o,
  output logic                      strobe_o,
  output spt_pkg::spt_res_t         res_o
);
  import spt_pkg::*;

  localparam int unsigned ReqW = $bits(spt_req_t);

  spt_bstate_e      state_q, state_d;
  logic [JobW-1:0]  job_q;
  spt_req_t         req;
  logic [IW-1:0]    idx;
  logic             matched;
  spt_mode_e        mode;
  logic [AddrW-1:0] expect_addr;
  logic             hit;
  logic             strobe_q, strobe_d;
  spt_res_t         res_q, res_d;
  logic [AddrW-1:0] access_total_q, access_total_d;
  logic [AddrW-1:0] hit_total_q, hit_total_d;
  logic [AddrW-1:0] drop_total_q, drop_total_d;

  assign req         = job_q[ReqW-1:0];
  assign idx         = job_q[ReqW +: IW];
  assign matched     = job_q[JobW-1];
  assign mode        = mode_i[idx];
  assign expect_addr = addr_stride_i.last_addr + addr_stride_i.stride;
  assign hit         = matched && (expect_addr == req.data_addr);

  always_comb begin
    state_d        = state_q;
    pop_o          = 1'b0;
    rd_en_o        = 1'b0;
    strobe_d       = 1'b0;
    res_d          = res_q;
    access_total_d = access_total_q;
    hit_total_d    = hit_total_q;
    drop_total_d   = drop_total_q;
    wr_o           = '0;
    wr_o.mode      = MODE_INVALID;
    wr_o.tag_use   = '{tag: req.instr_addr, last_use: req.timestamp};
    wr_o.addr_stride = '{last_addr: req.data_addr, stride: addr_stride_i.stride};

    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          rd_en_o = 1'b1;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        wr_o.tu_we     = 1'b1;
        access_total_d = access_total_q + 1'b1;
        res_d          = '0;
        strobe_d       = 1'b1;
        if (hit) begin
          hit_total_d          = hit_total_q + 1'b1;
          wr_o.ls_we           = 1'b1;
          wr_o.mode_we         = (mode == MODE_TRAINING);
          wr_o.mode            = MODE_ACTIVE;
          res_d.prefetch_valid = 1'b1;
          res_d.stride_hit     = 1'b1;
          res_d.prefetch_addr  = req.data_addr + addr_stride_i.stride;
        end else if (matched && mode == MODE_ACTIVE) begin
          // Drop the entry; keep its last address and stride.
          drop_total_d        = drop_total_q + 1'b1;
          wr_o.mode_we        = 1'b1;
          wr_o.mode           = MODE_INVALID;
          res_d.entry_dropped = 1'b1;
        end else if (matched) begin
          wr_o.ls_we              = 1'b1;
          wr_o.addr_stride.stride = req.data_addr - addr_stride_i.last_addr;
        end else begin
          wr_o.ls_we              = 1'b1;
          wr_o.mode_we            = 1'b1;
          wr_o.mode               = MODE_TRAINING;
          wr_o.addr_stride.stride = '0;
        end
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign rd_idx_o = job_i[ReqW +: IW];
  assign wr_idx_o = idx;
  assign idle_o   = (state_q == B_IDLE);
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      strobe_q       <= 1'b0;
      access_total_q <= '0;
      hit_total_q    <= '0;
      drop_total_q   <= '0;
    end else begin
      state_q        <= state_d;
      strobe_q       <= strobe_d;
      access_total_q <= access_total_d;
      hit_total_q    <= hit_total_d;
      drop_total_q   <= drop_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      job_q <= job_i;
    end
  end

endmodule

// File: hdl/stride_prefetch_table.sv
// ----------------------------------------------------------------------------
// stride_prefetch_table: stride prefetcher on a reference prediction table
// Fully associative table of ENTRIES entries (tag, last address, stride,
// mode, last-use time); one prefetch result per load.
// ----------------------------------------------------------------------------
// Pulse start with a load (instr_addr, data_addr, timestamp) while busy is
// low; exactly one result comes back on res_o, marked by strobe_o for a single
// cycle, and there is no way to hold it off, so capture it when strobe_o is
// high. An accepted load waits until the table is quiet, is swept entry by entry
// in the front end, passes the job queue, and is then read, checked and written
// back by the back end, which registers the result and its strobe. The front
// end looks at one entry per cycle through the single read port of the
// tag/last-use memory, and starts that sweep only after the previous load has
// written the table back. busy drops as soon as a load has left the front end,
// so the next load can be taken while the previous one is still being updated.
// ----------------------------------------------------------------------------
module stride_prefetch_table #(
  parameter int unsigned ENTRIES = spt_pkg::DefEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spt_pkg::spt_req_t req_i,
  output logic              strobe_o,
  output spt_pkg::spt_res_t res_o
);
  import spt_pkg::*;

  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned JobW = 1 + IW + $bits(spt_req_t);

  // Front end to queue.
  logic             push;
  logic [JobW-1:0]  push_job;

  // Queue to back end.
  logic             pop;
  logic             q_empty;
  logic [JobW-1:0]  head_job;

  // Table ports.
  logic             f_rd_en;
  logic [IW-1:0]    f_rd_idx;
  spt_tag_use_t     f_tag_use;
  logic             b_rd_en;
  logic [IW-1:0]    b_rd_idx;
  spt_addr_stride_t b_addr_stride;
  logic [IW-1:0]    wr_idx;
  spt_wr_t          wr;
  spt_mode_e        mode [ENTRIES];

  logic             back_idle;
  logic             quiet;

  // The table is stable once nothing is queued and the back end has finished.
  assign quiet = q_empty && back_idle;

  spt_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .req_i     (req_i),
    .quiet_i   (quiet),
    .mode_i    (mode),
    .rd_en_o   (f_rd_en),
    .rd_idx_o  (f_rd_idx),
    .tag_use_i (f_tag_use),
    .push_o    (push),
    .job_o     (push_job)
  );

  spt_fifo #(
    .DataW (JobW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (q_empty)
  );

  spt_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .f_rd_en_i       (f_rd_en),
    .f_rd_idx_i      (f_rd_idx),
    .f_tag_use_o     (f_tag_use),
    .b_rd_en_i       (b_rd_en),
    .b_rd_idx_i      (b_rd_idx),
    .b_addr_stride_o (b_addr_stride),
    .wr_idx_i        (wr_idx),
    .wr_i            (wr),
    .mode_o          (mode)
  );

  spt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .job_i         (head_job),
    .pop_o         (pop),
    .rd_en_o       (b_rd_en),
    .rd_idx_o      (b_rd_idx),
    .addr_stride_i (b_addr_stride),
    .mode_i        (mode),
    .wr_idx_o      (wr_idx),
    .wr_o          (wr),
    .idle_o        (back_idle),
    .strobe_o      (strobe_o),
    .res_o         (res_o)
  );

`ifndef ASSERT_OFF
  // Each load passes the back end's pop and update states, so strobes never touch.
  a_strobe_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("back-to-back result strobes");

  a_hit_means_prefetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (res_o.prefetch_valid == res_o.stride_hit) &&
                 !(res_o.stride_hit && res_o.entry_dropped))
    else $error("inconsistent result flags");

  a_no_hit_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !res_o.prefetch_valid) |-> (res_o.prefetch_addr == '0))
    else $error("prefetch address without a hit");
`endif

endmodule

// File: tb/tb_stride_prefetch_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stride_prefetch_table: self-checking bench for the stride prefetch table
// Drives load items through the start/busy handshake, predicts every result
// with a local copy of the prediction table and checks each strobed result,
// field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_stride_prefetch_table;
  import spt_pkg::*;

  localparam int unsigned TBL_ENTRIES = DefEntries;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned PHASE_LOADS = 220;
  localparam int unsigned MAX_STREAMS = 32;

  // One pending load: the request, the longest idle gap drawn before it, and
  // whether the sender must wait for all outstanding results first.
  typedef struct {
    spt_req_t    req;
    int unsigned max_gap;
    bit          drain;
  } load_item_t;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     load_start = 1'b0;
  spt_req_t load_req = '0;
  logic     busy;
  logic     strobe;
  spt_res_t res;

  stride_prefetch_table dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_n),
    .start    (load_start),
    .busy     (busy),
    .req_i    (load_req),
    .strobe_o (strobe),
    .res_o    (res)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow prediction table: same entry choice and update rules as the block.
  // --------------------------------------------------------------------------
  logic [63:0] tbl_tag    [TBL_ENTRIES];
  logic [63:0] tbl_last   [TBL_ENTRIES];
  logic [63:0] tbl_stride [TBL_ENTRIES];
  logic [63:0] tbl_use    [TBL_ENTRIES];
  spt_mode_e   tbl_mode   [TBL_ENTRIES];
  logic [63:0] lookups, stride_hits, drops, replacements;

  // Look up one load, update the shadow table and return the result it gives.
  function automatic spt_res_t predict_lookup(input spt_req_t r);
    int       sel;
    int       free_idx;
    int       oldest;
    bit       tag_match;
    spt_res_t out;
    sel       = -1;
    free_idx  = -1;
    oldest    = 0;
    tag_match = 1'b0;
    out       = '0;
    lookups++;
    // A valid matching tag wins at once; otherwise track the first free entry
    // and the least recently used valid one (ties keep the lowest index).
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      if (!tag_match) begin
        if (tbl_mode[i] != MODE_INVALID) begin
          if (tbl_tag[i] == r.instr_addr) begin
            tag_match = 1'b1;
            sel = i;
          end else if (tbl_use[i] < tbl_use[oldest]) begin
            oldest = i;
          end
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
    end
    if (!tag_match) begin
      if (free_idx >= 0) begin
        sel = free_idx;
      end else begin
        sel = oldest;
        replacements++;
      end
    end
    tbl_use[sel] = r.timestamp;
    if (tag_match) begin
      if (tbl_last[sel] + tbl_stride[sel] == r.data_addr) begin
        // Stride confirmed: promote training, advance, emit the next address.
        stride_hits++;
        if (tbl_mode[sel] == MODE_TRAINING) tbl_mode[sel] = MODE_ACTIVE;
        tbl_last[sel]      = r.data_addr;
        out.stride_hit     = 1'b1;
        out.prefetch_valid = 1'b1;
        out.prefetch_addr  = r.data_addr + tbl_stride[sel];
      end else if (tbl_mode[sel] == MODE_ACTIVE) begin
        // Drop the entry but keep its address and stride.
        tbl_mode[sel]     = MODE_INVALID;
        drops++;
        out.entry_dropped = 1'b1;
      end else begin
        tbl_stride[sel] = r.data_addr - tbl_last[sel];
        tbl_last[sel]   = r.data_addr;
      end
    end else begin
      tbl_tag[sel]    = r.instr_addr;
      tbl_mode[sel]   = MODE_TRAINING;
      tbl_stride[sel] = '0;
      tbl_last[sel]   = r.data_addr;
    end
    return out;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hand loads over from load_q, one per accepted start.
  // --------------------------------------------------------------------------
  load_item_t  load_q[$];
  spt_res_t    predicted_q[$];
  int unsigned loads_issued = 0;
  int unsigned results_seen = 0;
  int unsigned total_loads  = 0;
  int unsigned gap_left     = 0;
  bit          gap_armed    = 1'b0;
  int unsigned mismatches   = 0;

  always @(posedge clk_i) begin
    bit          taken;
    bit          fire;
    int unsigned outstanding;
    if (rst_n) begin
      taken = load_start && !busy;
      fire  = 1'b0;
      if (taken) begin
        // Predict at the accepting edge, in acceptance order.
        predicted_q.push_back(predict_lookup(load_req));
        loads_issued <= loads_issued + 1;
        void'(load_q.pop_front());
        gap_armed = 1'b0;
      end
      // Hold start and the item while busy; otherwise pick the next item.
      if (!load_start || taken) begin
        outstanding = loads_issued + taken - results_seen;
        if (load_q.size() > 0) begin
          if (!gap_armed) begin
            gap_left  = $urandom_range(0, load_q[0].max_gap);
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
          end else if (!load_q[0].drain || outstanding == 0) begin
            fire = 1'b1;
          end
        end
        load_start <= fire;
        if (fire) load_req <= load_q[0].req;
      end
    end
  end

  // Compare one result field; count and report a mismatch.
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: every strobe must match the oldest outstanding prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    spt_res_t want;
    if (rst_n && strobe) begin
      if (loads_issued == results_seen) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual %h", $time, res);
      end else begin
        want = predicted_q.pop_front();
        results_seen <= results_seen + 1;
        check_field("prefetch_valid", 64'(want.prefetch_valid), 64'(res.prefetch_valid));
        check_field("prefetch_addr", want.prefetch_addr, res.prefetch_addr);
        check_field("stride_hit", 64'(want.stride_hit), 64'(res.stride_hit));
        check_field("entry_dropped", 64'(want.entry_dropped), 64'(res.entry_dropped));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_load(input logic [63:0] pc, input logic [63:0] addr,
                          input logic [63:0] ts, input int unsigned max_gap,
                          input bit drain);
    load_item_t it;
    it.req.instr_addr = pc;
    it.req.data_addr  = addr;
    it.req.timestamp  = ts;
    it.max_gap        = max_gap;
    it.drain          = drain;
    load_q.push_back(it);
  endtask

  // Draw a stream stride: mostly small word multiples of either sign, now and
  // then zero or a full 64-bit value.
  function automatic logic [63:0] draw_stride();
    logic [63:0] st;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      st = '0;
    end else if (pick == 1) begin
      st = {$urandom, $urandom};
    end else begin
      st = 64'($urandom_range(1, 32)) * 8;
      if ($urandom_range(0, 1)) st = -st;
    end
    return st;
  endfunction

  logic [63:0] stream_pc   [MAX_STREAMS];
  logic [63:0] stream_next [MAX_STREAMS];
  logic [63:0] stream_step [MAX_STREAMS];
  logic [63:0] now_ts;

  initial begin
    int unsigned pool_sizes [RAND_PHASES];
    int unsigned pool;
    int unsigned k;
    int unsigned roll;
    int unsigned gap_max;
    logic [63:0] addr;
    logic [63:0] ts;

    for (int i = 0; i < TBL_ENTRIES; i++) begin
      tbl_tag[i]    = '0;
      tbl_last[i]   = '0;
      tbl_stride[i] = '0;
      tbl_use[i]    = '0;
      tbl_mode[i]   = MODE_INVALID;
    end
    lookups      = '0;
    stride_hits  = '0;
    drops        = '0;
    replacements = '0;

    // Directed: a stale zero tag in an invalid entry must not match; train,
    // promote, hit, then drop on a mismatch and reallocate the freed entry.
    add_load(64'd0, 64'd0, 64'd0, 3, 1'b0);
    add_load(64'd0, 64'd64, 64'd1, 3, 1'b0);
    add_load(64'd0, 64'd128, 64'd2, 3, 1'b0);
    add_load(64'd0, 64'd192, 64'd3, 3, 1'b0);
    add_load(64'd0, 64'd1000, 64'd4, 3, 1'b0);
    add_load(64'd0, 64'd1000, 64'd5, 3, 1'b0);
    // All-ones extremes, then a stride that wraps past the top of memory.
    add_load('1, '1, '1, 3, 1'b0);
    add_load('1, 64'd15, 64'd6, 3, 1'b0);
    add_load('1, 64'd31, 64'd7, 3, 1'b0);
    // Fill the table with equal last-use times, then force replacements:
    // the oldest entry goes, a tie going to the lowest index.
    for (int i = 0; i < TBL_ENTRIES - 2; i++) begin
      add_load(64'h8000_0000_0000_0100 + i, 64'h4000 + 64'(i) * 64, 64'd0, 3, 1'b0);
    end
    add_load(64'h5a5a_f00d_0000_0001, 64'h1234_5678, 64'd9, 3, 1'b0);
    add_load(64'h8000_0000_0000_0100, 64'h4000, 64'd10, 3, 1'b0);

    // Random: strided streams from a pool of load PCs, with broken strides,
    // stride changes and stray loads mixed in. Pool sizes below, at and above
    // the table size give steady hits as well as thrashing.
    pool_sizes = '{6, 12, 16, 20, 30};
    now_ts = 64'd100;
    for (int p = 0; p < RAND_PHASES; p++) begin
      pool    = pool_sizes[p];
      gap_max = (p == 2) ? 0 : 3;
      for (int s = 0; s < pool; s++) begin
        stream_pc[s]   = {$urandom, $urandom};
        stream_next[s] = {$urandom, $urandom};
        stream_step[s] = draw_stride();
      end
      for (int n = 0; n < PHASE_LOADS; n++) begin
        k    = $urandom_range(0, pool - 1);
        roll = $urandom_range(0, 99);
        // Timestamps mostly advance; sometimes repeat or jump anywhere.
        if (roll % 33 == 0) begin
          ts = {$urandom, $urandom};
        end else begin
          if (roll % 29 != 0) now_ts = now_ts + $urandom_range(1, 20);
          ts = now_ts;
        end
        if (roll < 75) begin
          addr = stream_next[k];
          stream_next[k] = addr + stream_step[k];
          add_load(stream_pc[k], addr, ts, gap_max, n == 0);
        end else if (roll < 85) begin
          addr = {$urandom, $urandom};
          stream_next[k] = addr + stream_step[k];
          add_load(stream_pc[k], addr, ts, gap_max, n == 0);
        end else if (roll < 92) begin
          stream_step[k] = draw_stride();
          addr = stream_next[k];
          stream_next[k] = addr + stream_step[k];
          add_load(stream_pc[k], addr, ts, gap_max, n == 0);
        end else begin
          add_load({$urandom, $urandom}, {$urandom, $urandom}, ts, gap_max, n == 0);
        end
      end
    end
    total_loads = load_q.size();

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // Wait for every load to be taken and answered, then watch for strays.
    while (loads_issued != total_loads || results_seen != loads_issued) begin
      @(posedge clk_i);
    end
    repeat (TBL_ENTRIES + 8) @(posedge clk_i);

    $display("Checked %0d loads in one directed and %0d random phases.",
             lookups, RAND_PHASES);
    $display("Stride hits %0d, active entries dropped %0d, LRU replacements %0d.",
             stride_hits, drops, replacements);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 300_000);
    $display("Timeout after %0t", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
hdl/spt_pkg.sv
hdl/spt_fifo.sv
hdl/spt_table.sv
hdl/spt_front.sv
hdl/spt_back.sv
hdl/stride_prefetch_table.sv
tb/tb_stride_prefetch_table.sv
